// ===== sv/cwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types and constants for the closed walk counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cwc_pkg;

  // Prime modulus for all walk counts
  localparam logic [29:0] WALK_MOD = 30'd998244353;
  localparam int          CNT_W    = 30;

  // Item kinds carried on tuser
  localparam logic FUNC_MARK  = 1'b0;
  localparam logic FUNC_COUNT = 1'b1;

  // Register indexes on the configuration channel
  localparam logic [7:0] CFG_NUM_NODES   = 8'd0;
  localparam logic [7:0] CFG_WALK_LENGTH = 8'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_RUN,
    ST_DRAIN
  } cwc_state_t;

endpackage

`default_nettype wire

// ===== sv/cwc_mod_add.sv =====
// ----------------------------------------------------------------------------
// cwc_mod_add
// Modular adder: (a + b) mod WALK_MOD for operands already below the modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_mod_add (
  input  wire logic [cwc_pkg::CNT_W-1:0] a,
  input  wire logic [cwc_pkg::CNT_W-1:0] b,
  output logic      [cwc_pkg::CNT_W-1:0] sum
);

  logic [cwc_pkg::CNT_W:0] raw;
  logic [cwc_pkg::CNT_W:0] red;

  // Sum stays below twice the modulus: one compare and subtract
  always_comb begin
    raw = {1'b0, a} + {1'b0, b};
    red = raw - {1'b0, cwc_pkg::WALK_MOD};
    if (raw >= {1'b0, cwc_pkg::WALK_MOD}) begin
      sum = red[cwc_pkg::CNT_W-1:0];
    end else begin
      sum = raw[cwc_pkg::CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/closed_walk_counter_mod.sv =====
// ----------------------------------------------------------------------------
// closed_walk_counter_mod
// Counts closed walks at node 1 of a given length, modulo 998244353, on the
// complete directed graph minus self-loops and minus loaded forbidden edges.
// ----------------------------------------------------------------------------
// Mark beats: accepted one per cycle while idle, no result.
// Count beats: one result each, for n = min(num_nodes, MAX_NODES) nodes and
//   L = walk_length steps; the single modular accumulator takes one
//   (source, destination) pair per cycle, and the result waits on m_tready.
//   Input is not ready meanwhile.
// Reset: clears registers, then sweeps the forbidden map one bit per cycle,
//   all MAX_NODES*MAX_NODES bits, with s_tready low (config still accepted).
`default_nettype none

module closed_walk_counter_mod #(
  parameter int MAX_NODES = 512
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [9:0] edge_from, [19:10] edge_to, [23:20] zero
  input  wire logic        s_tuser,   // [0] func
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [29:0] walk_count, [31:30] zero
  // configuration
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int MDEPTH = MAX_NODES * MAX_NODES;
  localparam int MW     = $clog2(MDEPTH);
  localparam int CW     = cwc_pkg::CNT_W;

  cwc_pkg::cwc_state_t state, state_next;

  // configuration registers
  logic [9:0]  num_nodes;
  logic [15:0] walk_length;

  // sequencer counters
  logic [MW-1:0] clr_addr;
  logic [AW-1:0] i_cnt, j_cnt, n_m1;
  logic [15:0]   steps_left;
  logic          cur_bank;

  // stage-1 (accumulate) registers
  logic          s1_valid, s1_self, s1_last_i, s1_wbank, s1_rbank;
  logic [AW-1:0] s1_j;

  // memories
  logic          forbid_mem [MDEPTH];
  logic [CW-1:0] cnt_mem0 [MAX_NODES];
  logic [CW-1:0] cnt_mem1 [MAX_NODES];
  logic          forbid_rd;
  logic [CW-1:0] cnt_rd0, cnt_rd1;

  logic [CW-1:0] acc, node0_val;

  // input beat decode
  logic [9:0]    edge_from, edge_to;
  logic          func;
  logic          in_beat, mark_we, count_go, in_range;
  logic [AW-1:0] from_idx, to_idx;

  assign edge_from = s_tdata[9:0];
  assign edge_to   = s_tdata[19:10];
  assign func      = s_tuser;
  assign in_beat   = s_tvalid && s_tready;
  assign in_range  = (edge_from != 10'd0) && (edge_to != 10'd0) &&
                     (32'(edge_from) <= MAX_NODES) && (32'(edge_to) <= MAX_NODES);
  assign from_idx  = AW'(edge_from - 10'd1);
  assign to_idx    = AW'(edge_to - 10'd1);
  assign mark_we   = in_beat && (func == cwc_pkg::FUNC_MARK) && in_range;
  assign count_go  = in_beat && (func == cwc_pkg::FUNC_COUNT);

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes   <= 10'd1;
      walk_length <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cwc_pkg::CFG_NUM_NODES:   num_nodes   <= cfg_data[9:0];
        cwc_pkg::CFG_WALK_LENGTH: walk_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer: next state and strobes
  logic clr_last, i_last, j_last, run_end, out_load, init_we;

  assign clr_last = (clr_addr == MW'(MDEPTH - 1));
  assign i_last   = (i_cnt == n_m1);
  assign j_last   = (j_cnt == n_m1);
  assign run_end  = i_last && j_last && (steps_left == 16'd1);

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    init_we    = 1'b0;
    case (state)
      cwc_pkg::ST_CLEAR: begin
        if (clr_last) state_next = cwc_pkg::ST_IDLE;
      end
      cwc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && func == cwc_pkg::FUNC_COUNT) begin
          state_next = (num_nodes == 10'd0) ? cwc_pkg::ST_DRAIN : cwc_pkg::ST_INIT;
        end
      end
      cwc_pkg::ST_INIT: begin
        init_we = 1'b1;
        if (i_last) begin
          state_next = (steps_left == 16'd0) ? cwc_pkg::ST_DRAIN : cwc_pkg::ST_RUN;
        end
      end
      cwc_pkg::ST_RUN: begin
        if (run_end) state_next = cwc_pkg::ST_DRAIN;
      end
      cwc_pkg::ST_DRAIN: begin
        if (!s1_valid && (!m_tvalid || m_tready)) begin
          out_load   = 1'b1;
          state_next = cwc_pkg::ST_IDLE;
        end
      end
      default: state_next = cwc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cwc_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // counters and bank pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else begin
      if (state == cwc_pkg::ST_CLEAR) clr_addr <= clr_addr + MW'(1);
      if (count_go) begin
        i_cnt      <= '0;
        j_cnt      <= '0;
        cur_bank   <= 1'b0;
        steps_left <= walk_length;
        n_m1       <= (32'(num_nodes) > MAX_NODES) ? AW'(MAX_NODES - 1)
                                                   : AW'(num_nodes - 10'd1);
      end
      if (state == cwc_pkg::ST_INIT) begin
        i_cnt <= i_last ? '0 : i_cnt + AW'(1);
      end
      if (state == cwc_pkg::ST_RUN) begin
        if (i_last) begin
          i_cnt <= '0;
          if (j_last) begin
            j_cnt      <= '0;
            cur_bank   <= ~cur_bank;
            steps_left <= steps_left - 16'd1;
          end else begin
            j_cnt <= j_cnt + AW'(1);
          end
        end else begin
          i_cnt <= i_cnt + AW'(1);
        end
      end
    end
  end

  // forbidden map: clear sweep / mark writes, pair read during run
  logic [MW-1:0] map_waddr, map_raddr;

  assign map_waddr = (state == cwc_pkg::ST_CLEAR) ? clr_addr
                     : MW'(from_idx) * MW'(MAX_NODES) + MW'(to_idx);
  assign map_raddr = MW'(i_cnt) * MW'(MAX_NODES) + MW'(j_cnt);

  always_ff @(posedge clk) begin
    if (state == cwc_pkg::ST_CLEAR) forbid_mem[map_waddr] <= 1'b0;
    else if (mark_we)              forbid_mem[map_waddr] <= 1'b1;
    forbid_rd <= forbid_mem[map_raddr];
  end

  // issue stage: register pair attributes alongside the memory reads
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= (state == cwc_pkg::ST_RUN);
    end
    s1_self   <= (i_cnt == j_cnt);
    s1_last_i <= i_last;
    s1_j      <= j_cnt;
    s1_wbank  <= ~cur_bank;
    s1_rbank  <= cur_bank;
  end

  // accumulate stage: shared modular adder
  logic [CW-1:0] prev_val, add_b, acc_sum;

  assign prev_val = s1_rbank ? cnt_rd1 : cnt_rd0;
  assign add_b    = (s1_valid && !s1_self && !forbid_rd) ? prev_val : '0;

  cwc_mod_add u_mod_add (
    .a   (acc),
    .b   (add_b),
    .sum (acc_sum)
  );

  always_ff @(posedge clk) begin
    if (count_go) begin
      node0_val <= '0;
    end else if (state == cwc_pkg::ST_INIT) begin
      acc       <= '0;
      node0_val <= CW'(1);
    end else if (s1_valid) begin
      acc <= s1_last_i ? '0 : acc_sum;
      if (s1_last_i && s1_j == '0) node0_val <= acc_sum;
    end
  end

  // count row banks: init writes bank 0, each step writes the other bank
  logic          we0, we1, row_we;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  assign row_we    = s1_valid && s1_last_i;
  assign we0       = init_we || (row_we && !s1_wbank);
  assign we1       = row_we && s1_wbank;
  assign cnt_waddr = init_we ? i_cnt : s1_j;
  assign cnt_wdata = init_we ? ((i_cnt == '0) ? CW'(1) : '0) : acc_sum;

  always_ff @(posedge clk) begin
    if (we0) cnt_mem0[cnt_waddr] <= cnt_wdata;
    if (we1) cnt_mem1[cnt_waddr] <= cnt_wdata;
    cnt_rd0 <= cnt_mem0[i_cnt];
    cnt_rd1 <= cnt_mem1[i_cnt];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (out_load) m_tdata <= {2'b00, node0_val};
  end

endmodule

`default_nettype wire

// ===== sv/cwc_checker.sv =====
// ----------------------------------------------------------------------------
// cwc_checker
// Port-level checks for the closed walk counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata
);

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // results are always reduced below the modulus
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:30] == 2'b00) && (m_tdata[29:0] < cwc_pkg::WALK_MOD))
    else $error("walk count not reduced");

  // the map clearing sweep holds off input right after reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready during map clear");

  // a count beat occupies the sequencer
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == cwc_pkg::FUNC_COUNT) |=> !s_tready)
    else $error("input ready while counting");

endmodule

bind closed_walk_counter_mod cwc_checker u_cwc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/closed_walk_counter_mod_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closed_walk_counter_mod_tb
// Self-checking bench for the closed walk counter. Edge marks and count
// requests stream in; every count beat is predicted with a plain dynamic
// programme over a local copy of the forbidden-edge map and the registers,
// and compared with the result beat. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module closed_walk_counter_mod_tb;

  localparam int          NODES_MAX    = 512;
  localparam int          SETTLE_CYC   = 8;
  localparam int          LONG_HOLD    = 3000;
  localparam int unsigned LIMIT_CYCLES = 20_000_000;

  typedef struct packed {
    logic       func;
    logic [9:0] dst_node;
    logic [9:0] src_node;
  } walk_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [9:0] edge_from, [19:10] edge_to, [23:20] zero
  logic        s_tuser = 1'b0;  // [0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;         // [29:0] walk_count, [31:30] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // beats taken at the last rising edge
  logic in_fire = 1'b0;
  logic m_fire = 1'b0;
  logic cfg_fire = 1'b0;

  // predictor state
  bit          forbidden [0:NODES_MAX-1][0:NODES_MAX-1];
  logic [9:0]  reg_nodes = 10'd1;
  logic [15:0] reg_len = 16'd1;

  walk_item_t  pending_items[$];
  logic [29:0] expected_counts[$];
  int unsigned mismatches = 0;
  int unsigned walk_results_seen = 0;
  int unsigned cycle_cnt = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_done = 1'b0;
  int          hold_left = 0;
  int          in_gap = 0;
  int          out_gap = 0;

  closed_walk_counter_mod #(
    .MAX_NODES(NODES_MAX)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Closed walks at node 1: row of counts stepped walk_length times
  function automatic logic [29:0] count_closed_walks();
    logic [29:0]     row_prev [NODES_MAX];
    logic [29:0]     row_next [NODES_MAX];
    longint unsigned acc;
    int unsigned     n;
    n = (reg_nodes > NODES_MAX) ? NODES_MAX : reg_nodes;
    if (n == 0) return '0;
    for (int i = 0; i < n; i++) row_prev[i] = '0;
    row_prev[0] = 30'd1;
    for (int step = 0; step < reg_len; step++) begin
      for (int j = 0; j < n; j++) begin
        acc = 0;
        for (int i = 0; i < n; i++)
          if (i != j && !forbidden[i][j]) acc += row_prev[i];
        row_next[j] = 30'(acc % cwc_pkg::WALK_MOD);
      end
      for (int j = 0; j < n; j++) row_prev[j] = row_next[j];
    end
    return row_prev[0];
  endfunction

  function automatic walk_item_t rand_item(int unsigned n);
    walk_item_t  it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.func     = (r < 25) ? cwc_pkg::FUNC_COUNT : cwc_pkg::FUNC_MARK;
    it.src_node = 10'($urandom);
    it.dst_node = 10'($urandom);
    if (r >= 25 && r < 30) begin
      // hits the active graph
      it.src_node = 10'($urandom_range(1, n));
      it.dst_node = 10'($urandom_range(1, n));
    end else if (r >= 30 && r < 75) begin
      it.src_node = 10'($urandom_range(1, 64));
      it.dst_node = 10'($urandom_range(1, 64));
    end
    return it;
  endfunction

  task automatic queue_item(logic func, int src, int dst);
    walk_item_t it;
    it.func     = func;
    it.src_node = 10'(src);
    it.dst_node = 10'(dst);
    pending_items.push_back(it);
  endtask

  // Sender holds back until every count beat has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || s_tvalid || expected_counts.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes both registers back to back, valid held between the beats
  task automatic set_regs(logic [15:0] nodes_word, logic [15:0] len_word);
    wait_idle();
    @(negedge clk);
    cfg_index <= cwc_pkg::CFG_NUM_NODES;
    cfg_data  <= nodes_word;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_index <= cwc_pkg::CFG_WALK_LENGTH;
    cfg_data  <= len_word;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: one beat in flight, fed from the pending queue
  always @(negedge clk) begin : in_driver
    logic       offer;
    walk_item_t beat;
    offer = s_tvalid && !in_fire;
    if (!offer && !rst) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        beat = pending_items.pop_front();
        s_tuser <= beat.func;
        s_tdata <= {4'b0, beat.dst_node, beat.src_node};
        offer = 1'b1;
        in_gap = no_idle ? 0 : pick_gap();
      end
    end
    s_tvalid <= offer;
  end

  // Result sink: random back-pressure plus one long hold-off
  always @(negedge clk) begin : out_sink
    if (hold_left > 0) begin
      hold_left--;
    end else if (!long_hold_done && walk_results_seen >= 40 &&
                 pending_items.size() > 20) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end else if (m_fire && !no_idle) begin
      out_gap = pick_gap();
    end else if (out_gap > 0) begin
      out_gap--;
    end
    m_tready <= (hold_left == 0 && out_gap == 0);
  end

  // Monitor: register mirror, prediction on input beats, result check
  always @(posedge clk) begin : monitor
    logic [29:0] want;
    in_fire  <= !rst && s_tvalid && s_tready;
    m_fire   <= !rst && m_tvalid && m_tready;
    cfg_fire <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cwc_pkg::CFG_NUM_NODES) reg_nodes = cfg_data[9:0];
        else if (cfg_index == cwc_pkg::CFG_WALK_LENGTH) reg_len = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == cwc_pkg::FUNC_COUNT) begin
          expected_counts.push_back(count_closed_walks());
        end else if (s_tdata[9:0] >= 1 && s_tdata[9:0] <= NODES_MAX &&
                     s_tdata[19:10] >= 1 && s_tdata[19:10] <= NODES_MAX) begin
          forbidden[9'(s_tdata[9:0] - 10'd1)][9'(s_tdata[19:10] - 10'd1)] = 1'b1;
        end
      end
      if (m_tvalid && m_tready) begin
        walk_results_seen++;
        if (expected_counts.size() == 0) begin
          $error("walk_count: no result expected, got %0d", m_tdata[29:0]);
          mismatches++;
        end else begin
          want = expected_counts.pop_front();
          if (m_tdata[29:0] !== want) begin
            $error("walk_count mismatch: expected %0d, got %0d", want, m_tdata[29:0]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("closed_walk_counter_mod_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned n;
    logic [15:0] nodes_word;
    logic [15:0] len_word;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset values first (also waits out the map clear)
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // no nodes at all
    set_regs(16'd0, 16'd5);
    queue_item(cwc_pkg::FUNC_COUNT, 1023, 1023);
    // three nodes; upper bits of the node word carry junk
    set_regs(16'hFC03, 16'd2);
    queue_item(cwc_pkg::FUNC_MARK, 0, 5);        // node out of range: ignored
    queue_item(cwc_pkg::FUNC_MARK, 5, 0);
    queue_item(cwc_pkg::FUNC_MARK, 513, 2);
    queue_item(cwc_pkg::FUNC_MARK, 2, 1023);
    queue_item(cwc_pkg::FUNC_MARK, 1023, 1023);
    queue_item(cwc_pkg::FUNC_MARK, 1, 1);        // self-loops: stored, no effect
    queue_item(cwc_pkg::FUNC_MARK, 512, 512);
    queue_item(cwc_pkg::FUNC_MARK, 512, 1);      // beyond num_nodes for now
    queue_item(cwc_pkg::FUNC_MARK, 4, 1);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // block most of the triangle: blocked edges outnumber allowed ones
    queue_item(cwc_pkg::FUNC_MARK, 2, 3);
    queue_item(cwc_pkg::FUNC_MARK, 3, 2);
    queue_item(cwc_pkg::FUNC_MARK, 1, 3);
    queue_item(cwc_pkg::FUNC_MARK, 3, 1);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // the earlier 4->1 mark now counts
    set_regs(16'd4, 16'd3);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // empty walk
    set_regs(16'd2, 16'd0);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    set_regs(16'd2, 16'd1000);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // longest walk on a single node
    set_regs(16'd1, 16'd65535);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    // node count above the maximum saturates
    set_regs(16'd1023, 16'd0);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);
    set_regs(16'd512, 16'd1);
    queue_item(cwc_pkg::FUNC_COUNT, 0, 0);

    // Random phases, small graphs and short walks
    for (int p = 0; p < 10; p++) begin
      if (p % 5 == 4) begin
        n = $urandom_range(13, 20);
        len_word = 16'($urandom_range(0, 4));
      end else begin
        n = $urandom_range(2, 12);
        len_word = 16'($urandom_range(0, 12));
      end
      nodes_word = 16'($urandom);
      nodes_word[9:0] = 10'(n);
      set_regs(nodes_word, len_word);
      no_idle = (p % 4 == 3);
      repeat (100) pending_items.push_back(rand_item(n));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_counts.size() != 0) begin
      $error("walk_count: %0d results never arrived", expected_counts.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("closed_walk_counter_mod_tb: done, clean");
    end else begin
      $display("closed_walk_counter_mod_tb: done, errors");
    end
    $finish;
  end

endmodule
